[design/ukfq_pkg.sv]
// Shared types and constants for the unique-key FIFO queue.
package ukfq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 16;
	localparam int VAL_W = 32;

	typedef enum logic [0:0] {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		op_t                     op;
		logic [KEY_W-1:0]        entry_key;
		logic signed [VAL_W-1:0] entry_value;
	} in_word_t;

	typedef struct packed {
		status_t                 status;
		logic [KEY_W-1:0]        out_key;
		logic signed [VAL_W-1:0] out_value;
		logic [CNT_W-1:0]        occupancy;
		logic                    is_empty;
	} out_word_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic occupied;
	} cell_ctrl_t;

endpackage

[design/ukfq_cell.sv]
// One queue slot: holds a pair, shifts toward the head, and flags a key match.
module ukfq_cell (
	input  logic                             clk,
	input  ukfq_pkg::cell_ctrl_t             ctrl,
	input  logic [ukfq_pkg::KEY_W-1:0]        load_key,
	input  logic signed [ukfq_pkg::VAL_W-1:0] load_value,
	input  logic [ukfq_pkg::KEY_W-1:0]        next_key,
	input  logic signed [ukfq_pkg::VAL_W-1:0] next_value,
	input  logic [ukfq_pkg::KEY_W-1:0]        probe_key,
	output logic [ukfq_pkg::KEY_W-1:0]        key,
	output logic signed [ukfq_pkg::VAL_W-1:0] value,
	output logic                             match
);

	logic [ukfq_pkg::KEY_W-1:0]        key_q;
	logic signed [ukfq_pkg::VAL_W-1:0] value_q;

	// take the neighbor's pair on a dequeue, the new pair on an enqueue into this slot
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= next_key;
			value_q <= next_value;
		end else if (ctrl.load) begin
			key_q   <= load_key;
			value_q <= load_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = ctrl.occupied && (key_q == probe_key);

endmodule

[design/unique_key_fifo_queue_top.sv]
// Top level of the unique-key FIFO queue: a chain of slot cells plus the count and result logic.
//
// Usage: assert start with a command word (enqueue or dequeue); busy never rises, so a command
// may be issued every cycle. The result word appears on result for exactly one cycle, with done
// high, on the cycle after start; the receiver cannot stall it and must take it then. Each
// command is handled in the cycle it is accepted: the duplicate check compares the new key
// against all occupied slot cells in parallel, and a dequeue shifts the whole chain one cell
// toward the head in that same cycle. Slot contents are not reset; only count_q and done are.
module unique_key_fifo_queue_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ukfq_pkg::in_word_t  cmd,
	output logic                done,
	output ukfq_pkg::out_word_t result
);

	logic [ukfq_pkg::CNT_W-1:0]        count_q;
	logic [ukfq_pkg::CNT_W-1:0]        count_d;
	logic                              done_q;
	ukfq_pkg::out_word_t               result_q;
	ukfq_pkg::out_word_t               result_d;

	ukfq_pkg::cell_ctrl_t              ctrl    [ukfq_pkg::DEPTH];
	logic [ukfq_pkg::KEY_W-1:0]        c_key   [ukfq_pkg::DEPTH];
	logic signed [ukfq_pkg::VAL_W-1:0] c_value [ukfq_pkg::DEPTH];
	logic [ukfq_pkg::DEPTH-1:0]        c_match;

	logic accept;
	logic dup;
	logic full;
	logic do_enq;
	logic do_deq;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign dup    = |c_match;
	assign full   = (count_q == ukfq_pkg::CNT_W'(ukfq_pkg::DEPTH));
	assign do_enq = accept && (cmd.op == ukfq_pkg::OP_ENQ) && !dup && !full;
	assign do_deq = accept && (cmd.op == ukfq_pkg::OP_DEQ) && (count_q != '0);

	genvar i;
	generate
		for (i = 0; i < ukfq_pkg::DEPTH; i++) begin : g_cell
			logic [ukfq_pkg::KEY_W-1:0]        nk;
			logic signed [ukfq_pkg::VAL_W-1:0] nv;

			assign ctrl[i].shift    = do_deq;
			assign ctrl[i].load     = do_enq && (count_q == ukfq_pkg::CNT_W'(i));
			assign ctrl[i].occupied = (ukfq_pkg::CNT_W'(i) < count_q);

			if (i == ukfq_pkg::DEPTH - 1) begin : g_last
				// nothing behind the last cell: it keeps its stale pair, now unoccupied
				assign nk = c_key[i];
				assign nv = c_value[i];
			end else begin : g_mid
				assign nk = c_key[i+1];
				assign nv = c_value[i+1];
			end

			ukfq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl[i]),
				.load_key   (cmd.entry_key),
				.load_value (cmd.entry_value),
				.next_key   (nk),
				.next_value (nv),
				.probe_key  (cmd.entry_key),
				.key        (c_key[i]),
				.value      (c_value[i]),
				.match      (c_match[i])
			);
		end
	endgenerate

	always_comb begin
		count_d  = count_q;
		result_d = '0;
		if (cmd.op == ukfq_pkg::OP_ENQ) begin
			if (dup) begin
				result_d.status = ukfq_pkg::ST_DUP;
			end else if (full) begin
				result_d.status = ukfq_pkg::ST_FULL;
			end else begin
				result_d.status = ukfq_pkg::ST_OK;
				count_d         = count_q + ukfq_pkg::CNT_W'(1);
			end
		end else begin
			if (count_q == '0) begin
				result_d.status = ukfq_pkg::ST_EMPTY;
			end else begin
				result_d.status    = ukfq_pkg::ST_OK;
				result_d.out_key   = c_key[0];
				result_d.out_value = c_value[0];
				count_d            = count_q - ukfq_pkg::CNT_W'(1);
			end
		end
		result_d.occupancy = count_d;
		result_d.is_empty  = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// capture the result word on accept; done marks the one cycle it is valid
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ukfq_pkg::CNT_W'(ukfq_pkg::DEPTH))
		else $error("occupancy count above depth");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command produced no result");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_deq |=> (count_q == $past(count_q) - ukfq_pkg::CNT_W'(1)))
		else $error("dequeue did not drop the count by one");

	a_dup_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.op == ukfq_pkg::OP_ENQ) && dup) |=> $stable(count_q))
		else $error("rejected duplicate changed the count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.occupancy == count_q))
		else $error("reported occupancy differs from held count");

endmodule

[dv/tb.sv]
// Testbench for the unique-key FIFO queue: directed and random command words checked against a queue model.
module tb;
	import ukfq_pkg::*;

	localparam int LIMIT_CYCLES = 100000;
	localparam int TAIL_CYCLES  = 4;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  cmd;
	logic      done;
	out_word_t result;

	// Shadow copy of the queue contents
	logic [KEY_W-1:0]        shadow_keys [DEPTH];
	logic signed [VAL_W-1:0] shadow_vals [DEPTH];
	int                      shadow_head;
	int                      shadow_tail;
	int                      shadow_count;

	out_word_t awaited_results[$];
	int        errors;
	int        cycles;
	int        status_tally[4];
	int        cmds_sent;

	unique_key_fifo_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t timeout with %0d results outstanding", $time, awaited_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	function automatic out_word_t predict_queue_result(in_word_t w);
		out_word_t r;
		bit        dup;
		int        pos;
		r = '0;
		r.status = ST_OK;
		if (w.op == OP_ENQ) begin
			dup = 1'b0;
			for (int n = 0; n < shadow_count; n++) begin
				pos = (shadow_head + n) % DEPTH;
				if (shadow_keys[pos] == w.entry_key)
					dup = 1'b1;
			end
			if (dup) begin
				r.status = ST_DUP;
			end else if (shadow_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_keys[shadow_tail] = w.entry_key;
				shadow_vals[shadow_tail] = w.entry_value;
				shadow_tail = (shadow_tail + 1) % DEPTH;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.out_key = shadow_keys[shadow_head];
				r.out_value = shadow_vals[shadow_head];
				shadow_head = (shadow_head + 1) % DEPTH;
				shadow_count--;
			end
		end
		r.occupancy = shadow_count[CNT_W-1:0];
		r.is_empty = (shadow_count == 0);
		return r;
	endfunction

	// Drive one word; hold start high until the edge that takes it
	task automatic send_cmd(in_word_t w, int idle_pct);
		out_word_t exp;
		int        gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		exp = predict_queue_result(w);
		awaited_results.push_back(exp);
		status_tally[exp.status]++;
		cmds_sent++;
	endtask

	task automatic send_enq(logic [KEY_W-1:0] k, logic signed [VAL_W-1:0] v, int idle_pct);
		in_word_t w;
		w.op = OP_ENQ;
		w.entry_key = k;
		w.entry_value = v;
		send_cmd(w, idle_pct);
	endtask

	task automatic send_deq(int idle_pct);
		in_word_t w;
		w.op = OP_DEQ;
		w.entry_key = 16'($urandom);
		w.entry_value = 32'($urandom);
		send_cmd(w, idle_pct);
	endtask

	// Hold off new words until every outstanding result is back
	task automatic drain_results();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, longint unsigned exp, longint unsigned act);
		if (exp !== act) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		out_word_t exp;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t unexpected result word: expected none actual %h", $time, result);
				errors++;
			end else begin
				exp = awaited_results.pop_front();
				check_field("status", exp.status, result.status);
				check_field("out_key", exp.out_key, result.out_key);
				check_field("out_value", 32'(exp.out_value), 32'(result.out_value));
				check_field("occupancy", exp.occupancy, result.occupancy);
				check_field("is_empty", exp.is_empty, result.is_empty);
			end
		end
	end

	task automatic test_dequeue_empty();
		send_deq(0);
		send_deq(0);
	endtask

	task automatic test_field_extremes();
		send_enq(16'h0000, 32'sh8000_0000, 0);
		send_enq(16'hFFFF, 32'sh7FFF_FFFF, 0);
		send_enq(16'hAAAA, 32'shFFFF_FFFF, 0);
		send_enq(16'h5555, 32'sh0000_0000, 0);
		repeat (4) send_deq(0);
		send_deq(0);
	endtask

	task automatic test_duplicate_key();
		send_enq(16'h0005, 32'sh1234_5678, 0);
		send_enq(16'h0005, 32'shDEAD_BEEF, 0);
		send_enq(16'h0006, 32'sh0000_0001, 0);
		send_enq(16'h0006, 32'sh0000_0002, 0);
		send_deq(0);
		send_enq(16'h0005, 32'sh0BAD_F00D, 0);
		repeat (2) send_deq(0);
	endtask

	// Fill to the bound, hit full and full-with-duplicate, then drain across the wrap
	task automatic test_full_and_wrap();
		for (int i = 0; i < DEPTH; i++)
			send_enq(16'(16'h0100 + i), 32'($urandom), 0);
		send_enq(16'h7777, 32'sh0000_0042, 0);
		send_enq(16'h0103, 32'sh0000_0043, 0);
		send_deq(0);
		send_enq(16'h7777, 32'sh0000_0044, 0);
		send_enq(16'h7777, 32'sh0000_0045, 0);
		repeat (DEPTH + 1) send_deq(0);
	endtask

	task automatic test_random_traffic(int n_items, int idle_pct);
		in_word_t w;
		int       enq_pct;
		int       run_left;
		int       pick;
		run_left = 0;
		enq_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			// Pick fill-heavy, drain-heavy or balanced runs at random so the queue swings full and empty
			if (run_left == 0) begin
				run_left = $urandom_range(10, 40);
				case ($urandom_range(2))
					0: enq_pct = 80;
					1: enq_pct = 25;
					default: enq_pct = 55;
				endcase
			end
			run_left--;
			w.entry_value = 32'($urandom);
			pick = $urandom_range(99);
			if (pick < 30 && shadow_count > 0)
				w.entry_key = shadow_keys[(shadow_head + $urandom_range(shadow_count - 1)) % DEPTH];
			else if (pick < 70)
				w.entry_key = 16'($urandom_range(31));
			else
				w.entry_key = 16'($urandom);
			w.op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
			send_cmd(w, idle_pct);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		errors = 0;
		cycles = 0;
		cmds_sent = 0;
		status_tally = '{default: 0};
		shadow_head = 0;
		shadow_tail = 0;
		shadow_count = 0;
		for (int i = 0; i < DEPTH; i++) begin
			shadow_keys[i] = '0;
			shadow_vals[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dequeue_empty();
		test_field_extremes();
		test_duplicate_key();
		drain_results();
		test_full_and_wrap();
		test_random_traffic(175, 0);
		test_random_traffic(175, 56);
		drain_results();
		test_random_traffic(175, 0);
		test_random_traffic(175, 21);

		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t %0d results never arrived", $time, awaited_results.size());
			errors++;
		end

		$display("tb: %0d commands: %0d ok, %0d duplicate, %0d empty dequeue, %0d full enqueue",
			cmds_sent, status_tally[ST_OK], status_tally[ST_DUP],
			status_tally[ST_EMPTY], status_tally[ST_FULL]);
		$display("tb: %0d mismatches over %0d cycles", errors, cycles);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
